>>> hw/rtl/kcg_pkg.sv
// Shared types, constants and control program for the k-combination generator.
package kcg_pkg;

    localparam int MAX_ELEMENTS_DEF = 32;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;
    localparam int CFG_W            = 6;
    localparam int MASK_W           = 32;

    localparam logic [CFG_W-1:0] SET_SIZE_RST     = 6'd4;
    localparam logic [CFG_W-1:0] CHOOSE_COUNT_RST = 6'd2;

    typedef enum logic [0:0] {
        REG_SET_SIZE     = 1'b0,
        REG_CHOOSE_COUNT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_EMIT,
        OP_WRAP,
        OP_RUN,
        OP_SKIP,
        OP_MOVE
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NO_SUBSET,
        COND_OUT_BUSY,
        COND_LAST,
        COND_BIT_SET,
        COND_BIT_CLEAR
    } cond_t;

    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    localparam upc_t STEP_WAIT  = 3'd0;
    localparam upc_t STEP_CHECK = 3'd1;
    localparam upc_t STEP_EMIT  = 3'd2;
    localparam upc_t STEP_WRAP  = 3'd3;
    localparam upc_t STEP_RUN   = 3'd4;
    localparam upc_t STEP_SKIP  = 3'd5;
    localparam upc_t STEP_MOVE  = 3'd6;

    // Jump to target when the condition holds, else fall through to the next step.
    function automatic uword_t ucode(upc_t addr);
        uword_t w;
        case (addr)
            STEP_WAIT:  w = '{op: OP_ACCEPT, cond: COND_NO_INPUT,  target: STEP_WAIT};
            STEP_CHECK: w = '{op: OP_NONE,   cond: COND_NO_SUBSET, target: STEP_WAIT};
            STEP_EMIT:  w = '{op: OP_EMIT,   cond: COND_OUT_BUSY,  target: STEP_EMIT};
            STEP_WRAP:  w = '{op: OP_WRAP,   cond: COND_LAST,      target: STEP_WAIT};
            STEP_RUN:   w = '{op: OP_RUN,    cond: COND_BIT_SET,   target: STEP_RUN};
            STEP_SKIP:  w = '{op: OP_SKIP,   cond: COND_BIT_CLEAR, target: STEP_SKIP};
            STEP_MOVE:  w = '{op: OP_MOVE,   cond: COND_ALWAYS,    target: STEP_WAIT};
            default:    w = '{op: OP_NONE,   cond: COND_ALWAYS,    target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/kcg_if.sv
// Item channel interfaces for the k-combination generator.
interface kcg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
    modport monitor (input valid, input restart, input ready);
endinterface

interface kcg_out_if;
    import kcg_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] chosen_mask;
    logic              is_last;

    modport source (output valid, output chosen_mask, output is_last, input ready);
    modport sink (input valid, input chosen_mask, input is_last, output ready);
    modport monitor (input valid, input chosen_mask, input is_last, input ready);
endinterface

>>> hw/rtl/k_combination_generator_top.sv
// Lexicographic k-combination generator with APB configuration and a microcoded sequencer.
//
// Usage: each item on the request channel asks for one subset. restart=1 reloads the
// first subset {0..k-1} before it is emitted. The result channel returns the subset as
// chosen_mask (bit x set for element x) with is_last on the final subset {n-k..n-1};
// the enumeration then wraps to the first subset. When k > n an item yields no result.
// set_size (n) lies at byte address 0 and choose_count (k) at 4; a write reloads the
// first subset. Write only while no item is in flight.
// The result register is loaded in the emit step. Sequence: an item with k > n passes only
// the wait and check steps; one that emits the final subset passes wait, check, emit and
// wrap; any other goes on through run, skip and move, the sequencer scanning the mask one
// element per cycle from the top of the set down to b, the element that moves up.
// Reset: n = 4, k = 2, first subset loaded, no result pending; no clearing pass.
// Stall: the result register holds the item until taken; the sequencer waits in its
// emit step only when the register is still full, so the next item may be accepted
// while a result waits.
module k_combination_generator_top #(
    parameter int MAX_ELEMENTS = kcg_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    kcg_in_if.sink                      request,
    kcg_out_if.source                   result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kcg_pkg::ADDR_W-1:0]  paddr,
    input  logic [kcg_pkg::DATA_W-1:0]  pwdata,
    output logic [kcg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import kcg_pkg::*;

    localparam int PW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int NW    = $clog2(MAX_ELEMENTS + 1);
    localparam int EXT_W = MAX_ELEMENTS + MASK_W;

    logic [CFG_W-1:0]        set_size_reg, set_size_next;
    logic [CFG_W-1:0]        choose_count_reg, choose_count_next;
    logic                    reload_reg, reload_next;
    upc_t                    upc_reg, upc_next;
    logic [MAX_ELEMENTS-1:0] comb_reg, comb_next;
    logic [PW-1:0]           ptr_reg, ptr_next;
    logic [NW-1:0]           run_reg, run_next;
    logic                    out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]       chosen_mask_reg;
    logic                    is_last_reg;

    uword_t                  uw;
    logic                    cfg_we;
    reg_idx_t                cfg_idx;
    logic [NW-1:0]           n_eff;
    logic                    no_subset;
    logic                    at_last;
    logic                    cur_bit;
    logic                    accept;
    logic                    out_busy;
    logic                    emit_fire;
    logic                    cond_true;
    logic [MAX_ELEMENTS-1:0] first_mask;
    logic [MAX_ELEMENTS-1:0] last_mask;
    logic [MAX_ELEMENTS-1:0] below_mask;
    logic [MAX_ELEMENTS-1:0] move_mask;
    logic [EXT_W-1:0]        comb_ext;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1]);

    always_comb
    begin
        case (cfg_idx)
            REG_SET_SIZE:     prdata = DATA_W'(set_size_reg);
            REG_CHOOSE_COUNT: prdata = DATA_W'(choose_count_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        set_size_next     = set_size_reg;
        choose_count_next = choose_count_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_SET_SIZE:     set_size_next = pwdata[CFG_W-1:0];
                REG_CHOOSE_COUNT: choose_count_next = pwdata[CFG_W-1:0];
                default:          set_size_next = set_size_reg;
            endcase
        end
    end

    assign reload_next = cfg_we;

    // Clamp n to the storage size.
    always_comb
    begin
        if (int'(set_size_reg) > MAX_ELEMENTS)
            n_eff = NW'(MAX_ELEMENTS);
        else
            n_eff = NW'(set_size_reg);
    end

    assign no_subset = int'(choose_count_reg) > int'(n_eff);

    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            first_mask[i] = i < int'(choose_count_reg);
            last_mask[i]  = (i < int'(n_eff)) &&
                            (i >= int'(n_eff) - int'(choose_count_reg));
            below_mask[i] = i < int'(ptr_reg);
            move_mask[i]  = (i > int'(ptr_reg)) &&
                            (i <= int'(ptr_reg) + int'(run_reg) + 1);
        end
    end

    assign at_last  = (choose_count_reg == '0) || (comb_reg == last_mask);
    assign cur_bit  = comb_reg[ptr_reg];
    assign comb_ext = EXT_W'(comb_reg);

    assign uw            = ucode(upc_reg);
    assign request.ready = (uw.op == OP_ACCEPT);
    assign accept        = request.valid && request.ready;
    assign out_busy      = out_valid_reg && !result.ready;
    assign emit_fire     = (uw.op == OP_EMIT) && !out_busy;

    always_comb
    begin
        case (uw.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_NO_INPUT:  cond_true = !request.valid;
            COND_NO_SUBSET: cond_true = no_subset;
            COND_OUT_BUSY:  cond_true = out_busy;
            COND_LAST:      cond_true = at_last;
            COND_BIT_SET:   cond_true = cur_bit;
            COND_BIT_CLEAR: cond_true = !cur_bit;
            default:        cond_true = 1'b0;
        endcase
        upc_next = cond_true ? uw.target : upc_reg + 1'b1;
    end

    always_comb
    begin
        comb_next = comb_reg;
        ptr_next  = ptr_reg;
        run_next  = run_reg;
        if (reload_reg)
            comb_next = first_mask;
        case (uw.op)
            OP_ACCEPT:
            begin
                if (accept && request.restart)
                    comb_next = first_mask;
            end
            OP_WRAP:
            begin
                if (at_last)
                    comb_next = first_mask;
                ptr_next = PW'(int'(n_eff) - 1);
                run_next = '0;
            end
            OP_RUN:
            begin
                if (cur_bit)
                begin
                    ptr_next = ptr_reg - 1'b1;
                    run_next = run_reg + 1'b1;
                end
            end
            OP_SKIP:
            begin
                if (!cur_bit)
                    ptr_next = ptr_reg - 1'b1;
            end
            OP_MOVE:
            begin
                comb_next = (comb_reg & below_mask) | move_mask;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg     <= SET_SIZE_RST;
            choose_count_reg <= CHOOSE_COUNT_RST;
            reload_reg       <= 1'b1;
            upc_reg          <= STEP_WAIT;
            out_valid_reg    <= 1'b0;
            ptr_reg          <= '0;
            run_reg          <= '0;
        end
        else
        begin
            set_size_reg     <= set_size_next;
            choose_count_reg <= choose_count_next;
            reload_reg       <= reload_next;
            upc_reg          <= upc_next;
            out_valid_reg    <= out_valid_next;
            ptr_reg          <= ptr_next;
            run_reg          <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        comb_reg <= comb_next;
        if (emit_fire)
        begin
            chosen_mask_reg <= comb_ext[MASK_W-1:0];
            is_last_reg     <= at_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.chosen_mask = chosen_mask_reg;
    assign result.is_last     = is_last_reg;

endmodule

>>> hw/rtl/kcg_checker.sv
// Port-level assertions for the k-combination generator and their bind.
module kcg_checker #(
    parameter int MAX_ELEMENTS = kcg_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic [kcg_pkg::MASK_W-1:0]  chosen_mask,
    input  logic                        is_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [kcg_pkg::ADDR_W-1:0]  paddr,
    input  logic [kcg_pkg::DATA_W-1:0]  pwdata
);
    import kcg_pkg::*;

    logic [CFG_W-1:0] n_sh_reg, n_sh_next;
    logic [CFG_W-1:0] k_sh_reg, k_sh_next;
    logic             cfg_we;
    logic             sized_ok;

    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        n_sh_next = n_sh_reg;
        k_sh_next = k_sh_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(paddr[ADDR_W-1]))
                REG_SET_SIZE:     n_sh_next = pwdata[CFG_W-1:0];
                REG_CHOOSE_COUNT: k_sh_next = pwdata[CFG_W-1:0];
                default:          n_sh_next = n_sh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_sh_reg <= SET_SIZE_RST;
            k_sh_reg <= CHOOSE_COUNT_RST;
        end
        else
        begin
            n_sh_reg <= n_sh_next;
            k_sh_reg <= k_sh_next;
        end
    end

    assign sized_ok = (int'(n_sh_reg) <= MAX_ELEMENTS) && (int'(n_sh_reg) <= MASK_W) &&
                      (k_sh_reg <= n_sh_reg);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(chosen_mask) && $stable(is_last))
        else $error("result payload changed while stalled");

    a_popcount: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sized_ok |->
            $countones(chosen_mask) == int'(k_sh_reg))
        else $error("subset size differs from choose_count");

    a_last_top: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_last && sized_ok && (k_sh_reg != '0) |->
            chosen_mask[5'(n_sh_reg - 6'd1)])
        else $error("final subset lacks the top element");

endmodule

bind k_combination_generator_top kcg_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_kcg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .chosen_mask  (result.chosen_mask),
    .is_last      (result.is_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata)
);

>>> tb/tb.sv
// Self-checking testbench for the k-combination generator: subset order, wrap, restart and APB setup.
`timescale 1ns / 100ps

module tb;
    import kcg_pkg::*;

    localparam int MAX_ELEMENTS   = MAX_ELEMENTS_DEF;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int TIMEOUT_NS     = 30_000_000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [MASK_W-1:0] chosen_mask;
        logic              is_last;
    } subset_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    kcg_in_if  request_if ();
    kcg_out_if result_if ();

    k_combination_generator_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [CFG_W-1:0] set_size_cfg;
    logic [CFG_W-1:0] choose_count_cfg;
    logic [5:0]       positions [MAX_ELEMENTS];
    subset_t          expected_subsets [$];
    subset_t          oldest_subset;
    int               error_count = 0;
    int               hold_cycles = 0;
    int               ready_gap   = 0;
    bit               tx_jitter   = 1'b1;
    bit               rx_jitter   = 1'b1;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic note_failure(input string msg);
        if (error_count < REPORT_LIMIT)
        begin
            $display("MISMATCH: %s", msg);
        end
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return $urandom_range(0, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic load_first();
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            positions[i] = 6'(i);
        end
    endtask

    task automatic predict_subset(input logic restart_bit);
        int      n;
        int      k;
        int      j;
        subset_t item;
        n = (set_size_cfg > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(set_size_cfg);
        k = int'(choose_count_cfg);
        if (restart_bit)
        begin
            load_first();
        end
        if (k > n)
        begin
            return;
        end
        item.chosen_mask = '0;
        for (int i = 0; i < k; i++)
        begin
            item.chosen_mask[positions[i]] = 1'b1;
        end
        item.is_last = (k == 0) || (int'(positions[0]) == n - k);
        expected_subsets.push_back(item);
        if (item.is_last)
        begin
            load_first();
        end
        else
        begin
            j = k;
            while (j > 0 && int'(positions[j-1]) >= n - k + j - 1)
            begin
                j--;
            end
            if (j == 0)
            begin
                load_first();
            end
            else
            begin
                positions[j-1] = positions[j-1] + 6'd1;
                for (int t = j; t < k; t++)
                begin
                    positions[t] = positions[t-1] + 6'd1;
                end
            end
        end
    endtask

    // result receiver: random gaps, plus a long hold when requested
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_if.ready <= 1'b0;
                hold_cycles--;
            end
            else if (ready_gap > 0)
            begin
                result_if.ready <= 1'b0;
                ready_gap--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                if (rx_jitter && $urandom_range(0, 3) == 0)
                begin
                    ready_gap = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_subsets.size() == 0)
            begin
                note_failure($sformatf("unexpected item mask=%h last=%b",
                                       result_if.chosen_mask, result_if.is_last));
            end
            else
            begin
                oldest_subset = expected_subsets.pop_front();
                if (result_if.chosen_mask !== oldest_subset.chosen_mask)
                begin
                    note_failure($sformatf("chosen_mask expected %h actual %h",
                                           oldest_subset.chosen_mask, result_if.chosen_mask));
                end
                if (result_if.is_last !== oldest_subset.is_last)
                begin
                    note_failure($sformatf("is_last expected %b actual %b",
                                           oldest_subset.is_last, result_if.is_last));
                end
            end
        end
    end

    task automatic send_request(input logic restart_bit);
        int gap;
        gap = tx_jitter ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            request_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        request_if.valid   <= 1'b1;
        request_if.restart <= restart_bit;
        do @(posedge clk); while (!request_if.ready);
        predict_subset(restart_bit);
    endtask

    task automatic drain_results();
        @(negedge clk);
        request_if.valid <= 1'b0;
        while (expected_subsets.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] readback;
        word = $urandom();
        word[CFG_W-1:0] = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SET_SIZE:     set_size_cfg     = value;
            REG_CHOOSE_COUNT: choose_count_cfg = value;
            default:          ;
        endcase
        load_first();
        if (readback !== DATA_W'(value))
        begin
            note_failure($sformatf("register %s expected %h actual %h",
                                   idx.name(), DATA_W'(value), readback));
        end
    endtask

    task automatic configure(input logic [CFG_W-1:0] n_val, input logic [CFG_W-1:0] k_val);
        if ($urandom_range(0, 1))
        begin
            write_register(REG_SET_SIZE, n_val);
            write_register(REG_CHOOSE_COUNT, k_val);
        end
        else
        begin
            write_register(REG_CHOOSE_COUNT, k_val);
            write_register(REG_SET_SIZE, n_val);
        end
    endtask

    task automatic test_reset_defaults();
        repeat (7) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain_results();
    endtask

    task automatic test_extreme_sizes();
        configure(6'd32, 6'd32);
        send_request(1'b0);
        send_request(1'b1);
        drain_results();
        configure(6'd32, 6'd0);
        send_request(1'b0);
        drain_results();
        configure(6'd0, 6'd0);
        send_request(1'b1);
        drain_results();
        configure(6'd40, 6'd31);
        repeat (3) send_request(1'b0);
        drain_results();
        configure(6'd33, 6'd32);
        send_request(1'b0);
        drain_results();
        configure(6'd1, 6'd1);
        repeat (2) send_request(1'b0);
        drain_results();
        configure(6'd32, 6'd1);
        send_request(1'b0);
        send_request(1'b1);
        drain_results();
    endtask

    task automatic test_no_subset();
        configure(6'd5, 6'd6);
        send_request(1'b0);
        send_request(1'b1);
        drain_results();
        configure(6'd63, 6'd63);
        send_request(1'b0);
        drain_results();
    endtask

    task automatic test_result_stall();
        configure(6'd6, 6'd3);
        tx_jitter   = 1'b0;
        hold_cycles = 300;
        repeat (40) send_request($urandom_range(0, 7) == 0);
        drain_results();
        tx_jitter = 1'b1;
    endtask

    task automatic test_sender_pause();
        configure(6'd7, 6'd2);
        repeat (12) send_request(1'b0);
        drain_results();
        repeat (12) send_request($urandom_range(0, 3) == 0);
        drain_results();
    endtask

    task automatic test_random_phases();
        int counted;
        int phase_len;
        int n_pick;
        int k_pick;
        int n_eff;
        int r;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                n_pick = $urandom_range(0, 8);
            end
            else if (r < 8)
            begin
                n_pick = $urandom_range(9, 32);
            end
            else if (r < 9)
            begin
                n_pick = $urandom_range(33, 63);
            end
            else
            begin
                n_pick = 32;
            end
            n_eff = (n_pick > MAX_ELEMENTS) ? MAX_ELEMENTS : n_pick;
            k_pick = ($urandom_range(0, 9) < 8) ? $urandom_range(0, n_eff) : $urandom_range(0, 63);
            configure(CFG_W'(n_pick), CFG_W'(k_pick));
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            phase_len = (k_pick > n_eff) ? $urandom_range(3, 6) : $urandom_range(20, 80);
            repeat (phase_len) send_request($urandom_range(0, 9) == 0);
            if (k_pick <= n_eff)
            begin
                counted += phase_len;
            end
            drain_results();
        end
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        request_if.valid   = 1'b0;
        request_if.restart = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        set_size_cfg       = SET_SIZE_RST;
        choose_count_cfg   = CHOOSE_COUNT_RST;
        load_first();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_extreme_sizes();
        test_no_subset();
        test_result_stall();
        test_sender_pause();
        test_random_phases();
        drain_results();

        if (expected_subsets.size() != 0)
        begin
            note_failure($sformatf("%0d items never produced", expected_subsets.size()));
        end
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/kcg_pkg.sv
hw/rtl/kcg_if.sv
hw/rtl/k_combination_generator_top.sv
hw/rtl/kcg_checker.sv
tb/tb.sv
